// File: sv/fifo_page_frame_manager_assert.svh
// Assertion macros for the page frame manager.
`ifndef FIFO_PAGE_FRAME_MANAGER_ASSERT_SVH
`define FIFO_PAGE_FRAME_MANAGER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FPFM_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FPFM_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FPFM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define FPFM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: sv/fpfm_pkg.sv
// ----------------------------------------------------------------------------
// fpfm_pkg
// Shared types for the page frame manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fpfm_pkg;
  localparam int ACTION_REFERENCE = 0;
  localparam int ACTION_RELEASE = 1;

  typedef struct packed {
    logic start_ref;
    logic start_rel;
    logic out_take;
  } fpfm_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fpfm_sts_t;
endpackage

// File: sv/fpfm_if.sv
// ----------------------------------------------------------------------------
// fpfm_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fpfm_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/fpfm_ctrl.sv
// ----------------------------------------------------------------------------
// fpfm_ctrl
// Sequencer that starts one request at a time and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpfm_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output fpfm_pkg::fpfm_cmd_t cmd,
  input  fpfm_pkg::fpfm_sts_t sts
);
  import fpfm_pkg::*;
  `include "fifo_page_frame_manager_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_WORK;
      S_WORK: if (sts.done) state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.start_ref = in_ready && in_valid && (in_action == 1'(ACTION_REFERENCE));
  assign cmd.start_rel = in_ready && in_valid && (in_action == 1'(ACTION_RELEASE));
  assign cmd.out_take = out_valid && out_ready;

  `FPFM_ASSERT_NEXT(a_start_busy, clk, rst_n, in_valid && in_ready, sts.busy)
  `FPFM_ASSERT_IMPL(a_out_idle, clk, rst_n, out_valid, !sts.busy)
  `FPFM_ASSERT_IMPL(a_done_work, clk, rst_n, sts.done, state_r == S_WORK)
endmodule

// File: sv/fpfm_dp.sv
// ----------------------------------------------------------------------------
// fpfm_dp
// Frame table, free queue and allocation-order queue with their walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fpfm_dp #(
  parameter int FRAMES = 128,
  parameter int PID_W = 8,
  parameter int PG_W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  fpfm_pkg::fpfm_cmd_t cmd,
  output fpfm_pkg::fpfm_sts_t sts,
  input  logic [PID_W-1:0] in_pid,
  input  logic [PG_W-1:0] in_page,
  output logic o_hit,
  output logic [6:0] o_frame,
  output logic o_evicted,
  output logic [7:0] o_ev_proc,
  output logic [7:0] o_ev_page,
  output logic [7:0] o_released,
  output logic [7:0] o_free
);
  import fpfm_pkg::*;
  `include "fifo_page_frame_manager_assert.svh"

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  typedef enum logic [11:0] {
    P_IDLE  = 12'b000000000001,
    P_SRD   = 12'b000000000010,
    P_SCHK  = 12'b000000000100,
    P_MISS  = 12'b000000001000,
    P_VICT  = 12'b000000010000,
    P_SHIFT = 12'b000000100000,
    P_POP   = 12'b000001000000,
    P_ALLOC = 12'b000010000000,
    P_RRD   = 12'b000100000000,
    P_RCHK  = 12'b001000000000,
    P_CRD   = 12'b010000000000,
    P_CCHK  = 12'b100000000000
  } phase_t;

  phase_t ph_r;
  logic [FRAMES-1:0] valid_r;
  logic [PID_W-1:0] owner_m [FRAMES];
  logic [PG_W-1:0] page_m [FRAMES];
  logic [AW-1:0] freeq_m [FRAMES];
  logic [AW-1:0] alloc_m [FRAMES];
  logic [CW-1:0] init_r;
  logic [AW-1:0] fhead_r;
  logic [CW-1:0] ftot_r, atot_r, k_r, w_r, rel_r;
  logic [PID_W-1:0] pid_r;
  logic [PG_W-1:0] pg_r;
  logic [PID_W-1:0] own_q;
  logic [PG_W-1:0] pg_q;
  logic [AW-1:0] fq_q, al_q, f_r;
  logic hit_r, ev_r;
  logic [PID_W-1:0] evp_r;
  logic [PG_W-1:0] evg_r;
  logic [AW-1:0] tail;
  logic [AW:0] tail_s;
  logic [AW-1:0] fq_raw;
  logic [AW-1:0] al_a;

  always_comb begin
    tail_s = {1'b0, fhead_r} + (AW+1)'(ftot_r);
    if (tail_s >= (AW+1)'(FRAMES)) tail_s = tail_s - (AW+1)'(FRAMES);
    tail = tail_s[AW-1:0];
  end

  // Free queue read port: entries not yet initialized read as their index.
  assign fq_q = (CW'(fhead_r) >= init_r) ? fhead_r : fq_raw;

  // The release walk fetches the entry below its count.
  assign al_a = (ph_r == P_RCHK) ? AW'(k_r - 1'b1) : k_r[AW-1:0];

  always_ff @(posedge clk) begin
    own_q <= owner_m[f_r];
    pg_q <= page_m[f_r];
    fq_raw <= freeq_m[fhead_r];
    al_q <= alloc_m[al_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      valid_r <= '0;
      fhead_r <= '0;
      ftot_r <= CW'(FRAMES);
      atot_r <= '0;
      init_r <= '0;
    end else begin
      unique case (ph_r)
        P_IDLE: begin
          if (cmd.start_ref || cmd.start_rel) begin
            pid_r <= in_pid;
            pg_r <= in_page;
            f_r <= '0;
            hit_r <= 1'b0;
            ev_r <= 1'b0;
            evp_r <= '0;
            evg_r <= '0;
            rel_r <= '0;
            w_r <= '0;
            if (cmd.start_ref) begin
              k_r <= '0;
              ph_r <= P_SRD;
            end else begin
              k_r <= atot_r;
              ph_r <= P_RCHK;
            end
          end
        end
        P_SRD: ph_r <= P_SCHK;
        P_SCHK: begin
          if (valid_r[f_r] && own_q == pid_r && pg_q == pg_r) begin
            hit_r <= 1'b1;
            ph_r <= P_IDLE;
          end else if (CW'(f_r) == CW'(FRAMES - 1)) begin
            ph_r <= P_MISS;
          end else begin
            f_r <= f_r + 1'b1;
            ph_r <= P_SRD;
          end
        end
        P_MISS: begin
          if (ftot_r == '0 && atot_r != '0) begin
            k_r <= CW'(1);
            ph_r <= P_VICT;
          end else begin
            ph_r <= P_POP;
          end
        end
        P_VICT: begin
          f_r <= al_q;
          k_r <= CW'(2);
          ph_r <= P_SHIFT;
        end
        P_SHIFT: begin
          if (k_r <= atot_r) begin
            alloc_m[AW'(k_r - CW'(2))] <= al_q;
            k_r <= k_r + 1'b1;
          end else begin
            atot_r <= atot_r - 1'b1;
            ev_r <= 1'b1;
            evp_r <= own_q;
            evg_r <= pg_q;
            valid_r[f_r] <= 1'b0;
            freeq_m[tail] <= f_r;
            if (CW'(tail) >= init_r) init_r <= CW'(tail) + 1'b1;
            ftot_r <= ftot_r + 1'b1;
            ph_r <= P_POP;
          end
        end
        P_POP: ph_r <= P_ALLOC;
        P_ALLOC: begin
          valid_r[fq_q] <= 1'b1;
          owner_m[fq_q] <= pid_r;
          page_m[fq_q] <= pg_r;
          alloc_m[atot_r[AW-1:0]] <= fq_q;
          atot_r <= atot_r + 1'b1;
          f_r <= fq_q;
          fhead_r <= (CW'(fhead_r) == CW'(FRAMES - 1)) ? '0 : fhead_r + 1'b1;
          ftot_r <= ftot_r - 1'b1;
          ph_r <= P_IDLE;
        end
        P_RRD: begin
          // The frame tested here was loaded on the previous pass through this state.
          if (k_r != atot_r && valid_r[f_r] && own_q == pid_r) begin
            valid_r[f_r] <= 1'b0;
            freeq_m[tail] <= f_r;
            if (CW'(tail) >= init_r) init_r <= CW'(tail) + 1'b1;
            ftot_r <= ftot_r + 1'b1;
            rel_r <= rel_r + 1'b1;
          end
          if (k_r == '0) begin
            f_r <= '0;
            ph_r <= P_CRD;
          end else begin
            f_r <= al_q;
            k_r <= k_r - 1'b1;
            ph_r <= P_RCHK;
          end
        end
        P_RCHK: ph_r <= P_RRD;
        P_CRD: ph_r <= P_CCHK;
        P_CCHK: begin
          if (k_r < atot_r) begin
            if (valid_r[al_q]) begin
              alloc_m[w_r[AW-1:0]] <= al_q;
              w_r <= w_r + 1'b1;
            end
            k_r <= k_r + 1'b1;
            ph_r <= P_CRD;
          end else begin
            atot_r <= w_r;
            ph_r <= P_IDLE;
          end
        end
        default: ph_r <= P_IDLE;
      endcase
    end
  end

  always_comb begin
    sts.busy = (ph_r != P_IDLE);
    sts.done = ((ph_r == P_SCHK) && valid_r[f_r] && own_q == pid_r && pg_q == pg_r)
            || (ph_r == P_ALLOC)
            || ((ph_r == P_CCHK) && !(k_r < atot_r));
  end

  assign o_hit = hit_r;
  assign o_frame = 7'(f_r);
  assign o_evicted = ev_r;
  assign o_ev_proc = 8'(evp_r);
  assign o_ev_page = 8'(evg_r);
  assign o_released = 8'(rel_r);
  assign o_free = 8'(ftot_r);

  `FPFM_ASSERT_IMPL(a_total, clk, rst_n, 1'b1, ftot_r + atot_r == CW'(FRAMES) || sts.busy)
  `FPFM_ASSERT_NEXT(a_hit_keeps, clk, rst_n, sts.done && ph_r == P_SCHK, $stable(ftot_r))
  `FPFM_ASSERT_IMPL(a_take_idle, clk, rst_n, cmd.out_take, !sts.busy)
endmodule

// File: sv/fifo_page_frame_manager.sv
// ----------------------------------------------------------------------------
// fifo_page_frame_manager
// FIFO page replacement over a shared pool of physical frames.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       in   action, process_id, virtual_page
// out      out  hit, frame_index, evicted, evicted_process, evicted_page,
//               released_count, free_count
// A reference scans the frame table one frame at a time; an eviction adds
// a walk of the allocation-order queue. A release walks the queue twice.
// One request is in work at a time. Reset needs no clearing pass. The result
// is held until taken; no new request is accepted meanwhile.
`timescale 1ns / 1ps
module fifo_page_frame_manager #(
  parameter int FRAMES = 128,
  parameter int PROCESS_ID_BITS = 8,
  parameter int PAGE_BITS = 8
) (
  input logic clk,
  input logic rst_n,
  fpfm_if.sink in_ch,
  fpfm_if.source out_ch
);
  import fpfm_pkg::*;

  fpfm_cmd_t cmd;
  fpfm_sts_t sts;
  logic hit, evd;
  logic [6:0] frm;
  logic [7:0] evp, evg, rel, fre;

  fpfm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_action(in_ch.data[0]), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  fpfm_dp #(.FRAMES(FRAMES), .PID_W(PROCESS_ID_BITS), .PG_W(PAGE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_pid(PROCESS_ID_BITS'(in_ch.data[8:1])),
    .in_page(PAGE_BITS'(in_ch.data[16:9])),
    .o_hit(hit), .o_frame(frm), .o_evicted(evd), .o_ev_proc(evp),
    .o_ev_page(evg), .o_released(rel), .o_free(fre)
  );

  assign out_ch.data = {fre, rel, evg, evp, evd, frm, hit};
endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO page frame manager. A directed table of
// references and releases is followed by random traffic with rotating idle
// patterns. Results are checked against typed rows or a frame-table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import fpfm_pkg::*;

  localparam int NFRAMES = 128;

  typedef struct packed {
    logic [7:0] virtual_page;
    logic [7:0] process_id;
    logic       action;
  } page_request_t;

  typedef struct packed {
    logic [7:0] free_count;
    logic [7:0] released_count;
    logic [7:0] evicted_page;
    logic [7:0] evicted_process;
    logic       evicted;
    logic [6:0] frame_index;
    logic       hit;
  } frame_result_t;

  typedef struct {
    page_request_t req;
    bit            typed;
    frame_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fpfm_if #(17) in_ch ();
  fpfm_if #(41) out_ch ();

  fifo_page_frame_manager DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  bit         frame_used [NFRAMES];
  logic [7:0] frame_owner_m [NFRAMES];
  logic [7:0] frame_page_m [NFRAMES];
  logic [6:0] free_list [NFRAMES];
  int         free_head_m;
  int         free_left;
  logic [6:0] age_list [NFRAMES];
  int         age_len;

  frame_result_t pending_results[$];
  int errors = 0;
  int send_idle = 0;
  int take_idle = 0;

  function automatic frame_result_t manage_frames(page_request_t r);
    frame_result_t o;
    int w;
    logic [6:0] f;
    logic [6:0] victim;
    bit found;
    o = '0;
    found = 0;
    if (r.action == 1'(ACTION_REFERENCE)) begin
      for (int k = 0; k < NFRAMES; k++) begin
        if (!found && frame_used[k] && frame_owner_m[k] == r.process_id &&
            frame_page_m[k] == r.virtual_page) begin
          found = 1;
          o.frame_index = 7'(k);
        end
      end
      if (found) begin
        o.hit = 1'b1;
      end else begin
        if (free_left == 0 && age_len > 0) begin
          victim = age_list[0];
          for (int k = 1; k < age_len; k++) age_list[k-1] = age_list[k];
          age_len--;
          o.evicted = 1'b1;
          o.evicted_process = frame_owner_m[victim];
          o.evicted_page = frame_page_m[victim];
          frame_used[victim] = 0;
          free_list[(free_head_m + free_left) % NFRAMES] = victim;
          free_left++;
        end
        f = free_list[free_head_m];
        free_head_m = (free_head_m + 1) % NFRAMES;
        free_left--;
        frame_used[f] = 1;
        frame_owner_m[f] = r.process_id;
        frame_page_m[f] = r.virtual_page;
        age_list[age_len] = f;
        age_len++;
        o.frame_index = f;
      end
    end else begin
      for (int k = age_len; k > 0; k--) begin
        f = age_list[k-1];
        if (frame_used[f] && frame_owner_m[f] == r.process_id) begin
          frame_used[f] = 0;
          free_list[(free_head_m + free_left) % NFRAMES] = f;
          free_left++;
          o.released_count++;
        end
      end
      w = 0;
      for (int k = 0; k < age_len; k++) begin
        if (frame_used[age_list[k]]) begin
          age_list[w] = age_list[k];
          w++;
        end
      end
      age_len = w;
    end
    o.free_count = 8'(free_left);
    return o;
  endfunction

  task automatic send_request(page_request_t r, bit typed, frame_result_t typed_res);
    frame_result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    predicted = manage_frames(r);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
  endtask

  function automatic frame_result_t res(logic hit, int frame, int rel, int free);
    frame_result_t o;
    o = '0;
    o.hit = hit;
    o.frame_index = 7'(frame);
    o.released_count = 8'(rel);
    o.free_count = 8'(free);
    return o;
  endfunction

  function automatic page_request_t req(int action, int pid, int page);
    page_request_t r;
    r.action = 1'(action);
    r.process_id = 8'(pid);
    r.virtual_page = 8'(page);
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit expected %h actual %h", $time, want.hit, got.hit);
          errors++;
        end
        if (got.frame_index !== want.frame_index) begin
          $display("%0t: frame_index expected %h actual %h", $time,
                   want.frame_index, got.frame_index);
          errors++;
        end
        if (got.evicted !== want.evicted) begin
          $display("%0t: evicted expected %h actual %h", $time, want.evicted,
                   got.evicted);
          errors++;
        end
        if (got.evicted_process !== want.evicted_process) begin
          $display("%0t: evicted_process expected %h actual %h", $time,
                   want.evicted_process, got.evicted_process);
          errors++;
        end
        if (got.evicted_page !== want.evicted_page) begin
          $display("%0t: evicted_page expected %h actual %h", $time,
                   want.evicted_page, got.evicted_page);
          errors++;
        end
        if (got.released_count !== want.released_count) begin
          $display("%0t: released_count expected %h actual %h", $time,
                   want.released_count, got.released_count);
          errors++;
        end
        if (got.free_count !== want.free_count) begin
          $display("%0t: free_count expected %h actual %h", $time,
                   want.free_count, got.free_count);
          errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= take_idle);
  end

  initial begin
    table_row_t directed [$];
    page_request_t r;
    int waited;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    for (int i = 0; i < NFRAMES; i++) begin
      frame_used[i] = 0;
      free_list[i] = 7'(i);
    end
    free_head_m = 0;
    free_left = NFRAMES;
    age_len = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{
      '{req(ACTION_REFERENCE, 0, 0), 1, res(0, 0, 0, 127)},
      '{req(ACTION_REFERENCE, 0, 0), 1, res(1, 0, 0, 127)},
      '{req(ACTION_REFERENCE, 255, 255), 1, res(0, 1, 0, 126)},
      '{req(ACTION_REFERENCE, 0, 255), 1, res(0, 2, 0, 125)},
      '{req(ACTION_REFERENCE, 255, 0), 1, res(0, 3, 0, 124)},
      '{req(ACTION_REFERENCE, 255, 255), 1, res(1, 1, 0, 124)},
      '{req(ACTION_RELEASE, 7, 0), 1, res(0, 0, 0, 124)},
      '{req(ACTION_RELEASE, 255, 255), 1, res(0, 0, 2, 126)},
      '{req(ACTION_REFERENCE, 255, 255), 1, res(0, 4, 0, 125)},
      '{req(ACTION_REFERENCE, 170, 85), 0, '0},
      '{req(ACTION_REFERENCE, 85, 170), 0, '0},
      '{req(ACTION_REFERENCE, 170, 85), 0, '0},
      '{req(ACTION_RELEASE, 0, 255), 0, '0},
      '{req(ACTION_REFERENCE, 0, 0), 0, '0},
      '{req(ACTION_RELEASE, 170, 0), 0, '0},
      '{req(ACTION_RELEASE, 85, 0), 0, '0},
      '{req(ACTION_RELEASE, 255, 0), 0, '0},
      '{req(ACTION_RELEASE, 0, 0), 0, '0},
      '{req(ACTION_RELEASE, 0, 0), 0, '0}
    };
    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].res);

    for (int i = 0; i < 510; i++) begin
      if (i == 0) begin
        send_idle = 7;
        take_idle = 65;
      end else if (i == 170) begin
        send_idle = 65;
        take_idle = 7;
      end else if (i == 340) begin
        send_idle = 0;
        take_idle = 0;
      end
      r.action = ($urandom_range(99) < 6) ? 1'(ACTION_RELEASE) : 1'(ACTION_REFERENCE);
      r.process_id = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 5))
                                                : 8'($urandom_range(0, 255));
      r.virtual_page = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 31))
                                                  : 8'($urandom_range(0, 255));
      send_request(r, 0, '0);
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2000) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
